// ----- rtl/core/audio_hpf_gate_agc_chain_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Audio conditioning chain: assertion macros
// Shared concurrent assertion forms for the chain's modules.
// ----------------------------------------------------------------------------
`ifndef AUDIO_HPF_GATE_AGC_CHAIN_UNIT_DEFINES_SVH
`define AUDIO_HPF_GATE_AGC_CHAIN_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define AHGA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define AHGA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ahga_pkg.sv -----
// ----------------------------------------------------------------------------
// Audio conditioning chain package
// Command and status types between controller and datapath, register codes
// and register reset values.
// ----------------------------------------------------------------------------
package ahga_pkg;

  localparam int CFG_INDEX_W = 3;

  // Widths at which the reset values below are given
  localparam int REF_COEFF_W = 16;
  localparam int REF_LEVEL_W = 15;

  localparam logic [2:0]  RST_STAGE_EN  = 3'd7;
  localparam logic [31:0] RST_HP_POLE   = 32'd62616;
  localparam logic [31:0] RST_HP_GAIN   = 32'd64076;
  localparam logic [31:0] RST_GATE_THR  = 32'd655;
  localparam logic [31:0] RST_GATE_RAT  = 32'd26214;
  localparam logic [31:0] RST_ATTACK    = 32'd65495;
  localparam logic [31:0] RST_RELEASE   = 32'd65528;
  localparam logic [31:0] RST_TARGET    = 32'd9830;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STAGE_EN,
    REG_HP_POLE,
    REG_HP_GAIN,
    REG_GATE_THR,
    REG_GATE_RATIO,
    REG_ATTACK,
    REG_RELEASE,
    REG_TARGET
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MUL_HP_DIFF,
    MUL_HP_POLE,
    MUL_GATE,
    MUL_ENV_HOLD,
    MUL_ENV_NEW,
    MUL_GAIN
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    WB_NONE,
    WB_HP,
    WB_SAMPLE,
    WB_ENV
  } wb_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    wb_sel_t  wb_sel;
    logic     div_start;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic hp_en;
    logic gate_en;
    logic agc_en;
    logic gate_hit;
    logic env_big;
    logic div_busy;
  } dp_status_t;

  // Rescale a fraction given at one width to another width
  function automatic logic [31:0] scale_frac(input logic [31:0] value, input int from_w,
                                             input int to_w);
    logic [31:0] r;
    if (to_w >= from_w) begin
      r = value << (to_w - from_w);
    end else begin
      r = value >> (from_w - to_w);
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/ahga_div.sv -----
// ----------------------------------------------------------------------------
// Gain divider
// Restoring divider, one quotient bit a cycle: gain = (target << CW) / env.
// Quotients that would exceed the gain range end at once as all ones.
// ----------------------------------------------------------------------------
`include "audio_hpf_gate_agc_chain_unit_defines.svh"

module ahga_div #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEFF_WIDTH  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [SAMPLE_WIDTH-2:0]   target,
  input  logic [SAMPLE_WIDTH:0]     divisor,
  output logic                      busy,
  output logic [COEFF_WIDTH+3:0]    quotient
);
  import ahga_pkg::*;

  localparam int EW    = SAMPLE_WIDTH + 1;
  localparam int UW    = COEFF_WIDTH + 4;
  localparam int NW    = SAMPLE_WIDTH - 1 + COEFF_WIDTH;
  localparam int DW    = EW + UW - 1;
  localparam int CNT_W = $clog2(UW);

  logic [NW-1:0]    rem;
  logic [DW-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic             skip;
  logic             ge;

  // Quotient of 16 * 2^CW or more clamps to the top of the gain range anyway
  assign skip = (EW + 4)'(target) >= {divisor, 4'b0000};
  assign ge   = DW'(rem) >= dvs;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        if (skip) begin
          quotient <= '1;
        end else begin
          rem      <= {target, {COEFF_WIDTH{1'b0}}};
          dvs      <= {divisor, {(UW-1){1'b0}}};
          cnt      <= CNT_W'(UW - 1);
          quotient <= '0;
          busy     <= 1'b1;
        end
      end else if (busy) begin
        quotient <= {quotient[UW-2:0], ge};
        if (ge) begin
          rem <= rem - dvs[NW-1:0];
        end
        dvs <= dvs >> 1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  `AHGA_ASSERT_IMP(a_no_restart, clk, rst, start, !busy, "divider restarted while busy")
  `AHGA_ASSERT_NEXT(a_last_bit, clk, rst, busy && cnt == '0, !busy, "divider overran")
  `AHGA_ASSERT_NEXT(a_skip_sat, clk, rst, start && skip, !busy && quotient == '1,
                    "saturating divide did not finish at once")

endmodule

// ----- rtl/core/ahga_dp.sv -----
// ----------------------------------------------------------------------------
// Audio conditioning chain datapath
// Configuration registers, filter and envelope state, one shared multiplier
// with accumulator, rounding and saturation, gain divider and result register.
// ----------------------------------------------------------------------------
module ahga_dp #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEFF_WIDTH  = 16,
  parameter int CFG_DATA_W   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [ahga_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]             cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_sample,
  input  ahga_pkg::dp_cmd_t                 cmd,
  output ahga_pkg::dp_status_t              status,
  output logic signed [SAMPLE_WIDTH-1:0]    out_sample,
  output logic [7:0]                        envelope_level
);
  import ahga_pkg::*;

  localparam int QW        = SAMPLE_WIDTH + 2;
  localparam int EW        = SAMPLE_WIDTH + 1;
  localparam int UW        = COEFF_WIDTH + 4;
  localparam int AW        = UW + 1 + QW;
  localparam int LW        = EW + 8;
  localparam int ONE_S     = 2 ** (SAMPLE_WIDTH - 1);
  localparam int MAX_Q2    = 2 ** (SAMPLE_WIDTH + 1) - 1;
  localparam int MIN_Q2    = -(2 ** (SAMPLE_WIDTH + 1));
  localparam int ONE_C     = 2 ** COEFF_WIDTH;
  localparam int HALF_C    = 2 ** (COEFF_WIDTH - 1);
  localparam int GAIN_MIN  = (ONE_C + 5) / 10;
  localparam int GAIN_MAX  = 10 * ONE_C;
  localparam int ENV_FLOOR = ONE_S / 1000;

  logic [2:0]                stage_en;
  logic [COEFF_WIDTH-1:0]    hp_pole;
  logic [COEFF_WIDTH-1:0]    hp_gain;
  logic [SAMPLE_WIDTH-2:0]   gate_thr;
  logic [COEFF_WIDTH-1:0]    gate_ratio;
  logic [COEFF_WIDTH-1:0]    attack;
  logic [COEFF_WIDTH-1:0]    release_k;
  logic [SAMPLE_WIDTH-2:0]   target;

  logic signed [SAMPLE_WIDTH-1:0] x;
  logic signed [SAMPLE_WIDTH-1:0] x1;
  logic signed [QW-1:0]           y1;
  logic signed [QW-1:0]           s;
  logic [EW-1:0]                  env;

  logic signed [AW-1:0] prod;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] acc_rnd;
  logic signed [AW-1:0] rnd_q;
  logic signed [QW-1:0] q2_sat;
  logic [EW-1:0]        env_sat;

  logic signed [SAMPLE_WIDTH:0] diff;
  logic signed [QW:0]           s_wide;
  logic [QW:0]                  abs_wide;
  logic [QW-1:0]                mag;
  logic [EW-1:0]                mag_sat;
  logic [COEFF_WIDTH-1:0]       env_k;
  logic [COEFF_WIDTH:0]         k_comp;
  logic                         env_big;

  logic [UW-1:0]        op_u;
  logic signed [QW-1:0] op_s;
  logic [UW-1:0]        quotient;
  logic [UW-1:0]        gain;
  logic                 div_busy;

  logic signed [SAMPLE_WIDTH-1:0] out_sat;
  logic [LW-1:0]                  lvl_full;
  logic [LW-1:0]                  lvl_shift;
  logic [7:0]                     lvl_sat;

  // Operand preparation
  assign diff     = {x[SAMPLE_WIDTH-1], x} - {x1[SAMPLE_WIDTH-1], x1};
  assign s_wide   = {s[QW-1], s};
  assign abs_wide = s[QW-1] ? (~s_wide + 1'b1) : s_wide;
  assign mag      = abs_wide[QW-1:0];
  assign mag_sat  = mag[QW-1] ? {EW{1'b1}} : mag[EW-1:0];
  assign env_k    = (mag_sat > env) ? attack : release_k;
  assign k_comp   = {1'b1, {COEFF_WIDTH{1'b0}}} - {1'b0, env_k};
  assign env_big  = env > EW'(ENV_FLOOR);

  always_comb begin
    op_u = '0;
    op_s = '0;
    case (cmd.mul_sel)
      MUL_HP_DIFF: begin
        op_u = UW'(hp_gain);
        op_s = {diff[SAMPLE_WIDTH], diff};
      end
      MUL_HP_POLE: begin
        op_u = UW'(hp_pole);
        op_s = y1;
      end
      MUL_GATE: begin
        op_u = UW'(gate_ratio);
        op_s = s;
      end
      MUL_ENV_HOLD: begin
        op_u = UW'(env_k);
        op_s = {1'b0, env};
      end
      MUL_ENV_NEW: begin
        op_u = UW'(k_comp);
        op_s = {1'b0, mag_sat};
      end
      MUL_GAIN: begin
        op_u = gain;
        op_s = s;
      end
      default: ;
    endcase
  end

  // Round half up at the coefficient point, then saturate
  assign acc_rnd = acc + AW'(HALF_C);
  assign rnd_q   = acc_rnd >>> COEFF_WIDTH;

  always_comb begin
    if (rnd_q > AW'(MAX_Q2)) begin
      q2_sat = {1'b0, {(QW-1){1'b1}}};
    end else if (rnd_q < AW'(MIN_Q2)) begin
      q2_sat = {1'b1, {(QW-1){1'b0}}};
    end else begin
      q2_sat = rnd_q[QW-1:0];
    end
    if (rnd_q[AW-1]) begin
      env_sat = '0;
    end else if (rnd_q > AW'(MAX_Q2)) begin
      env_sat = {EW{1'b1}};
    end else begin
      env_sat = rnd_q[EW-1:0];
    end
  end

  // Gain in Q4.CW, unity at a near-silent envelope
  always_comb begin
    if (!env_big) begin
      gain = UW'(ONE_C);
    end else if (quotient < UW'(GAIN_MIN)) begin
      gain = UW'(GAIN_MIN);
    end else if (quotient > UW'(GAIN_MAX)) begin
      gain = UW'(GAIN_MAX);
    end else begin
      gain = quotient;
    end
  end

  ahga_div #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEFF_WIDTH  (COEFF_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .target   (target),
    .divisor  (env),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Result formatting
  assign lvl_full  = {env, 8'b0} - {8'b0, env};
  assign lvl_shift = lvl_full >> (SAMPLE_WIDTH - 1);
  assign lvl_sat   = (lvl_shift > LW'(255)) ? 8'hFF : lvl_shift[7:0];

  always_comb begin
    if (s > QW'(ONE_S - 1)) begin
      out_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end else if (s < QW'(-ONE_S)) begin
      out_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      out_sat = s[SAMPLE_WIDTH-1:0];
    end
  end

  always_comb begin
    status.hp_en    = stage_en[0];
    status.gate_en  = stage_en[1];
    status.agc_en   = stage_en[2];
    status.gate_hit = mag < QW'(gate_thr);
    status.env_big  = env_big;
    status.div_busy = div_busy;
  end

  // Configuration and filter/envelope state
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_en   <= RST_STAGE_EN;
      hp_pole    <= COEFF_WIDTH'(scale_frac(RST_HP_POLE, REF_COEFF_W, COEFF_WIDTH));
      hp_gain    <= COEFF_WIDTH'(scale_frac(RST_HP_GAIN, REF_COEFF_W, COEFF_WIDTH));
      gate_thr   <= (SAMPLE_WIDTH-1)'(scale_frac(RST_GATE_THR, REF_LEVEL_W, SAMPLE_WIDTH - 1));
      gate_ratio <= COEFF_WIDTH'(scale_frac(RST_GATE_RAT, REF_COEFF_W, COEFF_WIDTH));
      attack     <= COEFF_WIDTH'(scale_frac(RST_ATTACK, REF_COEFF_W, COEFF_WIDTH));
      release_k  <= COEFF_WIDTH'(scale_frac(RST_RELEASE, REF_COEFF_W, COEFF_WIDTH));
      target     <= (SAMPLE_WIDTH-1)'(scale_frac(RST_TARGET, REF_LEVEL_W, SAMPLE_WIDTH - 1));
      x1         <= '0;
      y1         <= '0;
      env        <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_STAGE_EN:   stage_en   <= cfg_data[2:0];
          REG_HP_POLE:    hp_pole    <= cfg_data[COEFF_WIDTH-1:0];
          REG_HP_GAIN:    hp_gain    <= cfg_data[COEFF_WIDTH-1:0];
          REG_GATE_THR:   gate_thr   <= cfg_data[SAMPLE_WIDTH-2:0];
          REG_GATE_RATIO: gate_ratio <= cfg_data[COEFF_WIDTH-1:0];
          REG_ATTACK:     attack     <= cfg_data[COEFF_WIDTH-1:0];
          REG_RELEASE:    release_k  <= cfg_data[COEFF_WIDTH-1:0];
          REG_TARGET:     target     <= cfg_data[SAMPLE_WIDTH-2:0];
        endcase
      end
      if (cmd.wb_sel == WB_HP) begin
        x1 <= x;
        y1 <= q2_sat;
      end
      if (cmd.wb_sel == WB_ENV) begin
        env <= env_sat;
      end
    end
  end

  // Working sample, multiplier, accumulator, result register
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x <= in_sample;
      s <= {{2{in_sample[SAMPLE_WIDTH-1]}}, in_sample};
    end else if (cmd.wb_sel == WB_HP || cmd.wb_sel == WB_SAMPLE) begin
      s <= q2_sat;
    end
    if (cmd.mul_en) begin
      prod <= $signed({1'b0, op_u}) * op_s;
    end
    case (cmd.acc_op)
      ACC_LOAD: acc <= prod;
      ACC_ADD:  acc <= acc + prod;
      default:  ;
    endcase
    if (cmd.out_load) begin
      out_sample     <= out_sat;
      envelope_level <= lvl_sat;
    end
  end

endmodule

// ----- rtl/core/ahga_ctrl.sv -----
// ----------------------------------------------------------------------------
// Audio conditioning chain controller
// Sequences filter, gate and gain control steps on the shared datapath and
// owns the input and result handshakes.
// ----------------------------------------------------------------------------
`include "audio_hpf_gate_agc_chain_unit_defines.svh"

module ahga_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  ahga_pkg::dp_status_t  status,
  output ahga_pkg::dp_cmd_t     cmd
);
  import ahga_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_HP_M1,
    ST_HP_M2,
    ST_HP_ACC,
    ST_HP_WB,
    ST_GATE_CHK,
    ST_GATE_M,
    ST_GATE_ACC,
    ST_GATE_WB,
    ST_AGC_CHK,
    ST_ENV_M1,
    ST_ENV_M2,
    ST_ENV_ACC,
    ST_ENV_WB,
    ST_GAIN_CHK,
    ST_DIV_WAIT,
    ST_GAIN_M,
    ST_GAIN_ACC,
    ST_GAIN_WB,
    ST_FINISH
  } state_t;

  state_t state;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE:     cmd.load_in = in_valid;
      ST_HP_M1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_HP_DIFF;
      end
      ST_HP_M2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_HP_POLE;
        cmd.acc_op  = ACC_LOAD;
      end
      ST_HP_ACC:   cmd.acc_op = ACC_ADD;
      ST_HP_WB:    cmd.wb_sel = WB_HP;
      ST_GATE_M: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GATE;
      end
      ST_GATE_ACC: cmd.acc_op = ACC_LOAD;
      ST_GATE_WB:  cmd.wb_sel = WB_SAMPLE;
      ST_ENV_M1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ENV_HOLD;
      end
      ST_ENV_M2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ENV_NEW;
        cmd.acc_op  = ACC_LOAD;
      end
      ST_ENV_ACC:  cmd.acc_op = ACC_ADD;
      ST_ENV_WB:   cmd.wb_sel = WB_ENV;
      ST_GAIN_CHK: cmd.div_start = status.env_big;
      ST_GAIN_M: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GAIN;
      end
      ST_GAIN_ACC: cmd.acc_op = ACC_LOAD;
      ST_GAIN_WB:  cmd.wb_sel = WB_SAMPLE;
      ST_FINISH:   cmd.out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= status.hp_en ? ST_HP_M1 : ST_GATE_CHK;
          end
        end
        ST_HP_M1:    state <= ST_HP_M2;
        ST_HP_M2:    state <= ST_HP_ACC;
        ST_HP_ACC:   state <= ST_HP_WB;
        ST_HP_WB:    state <= ST_GATE_CHK;
        ST_GATE_CHK: begin
          state <= (status.gate_en && status.gate_hit) ? ST_GATE_M : ST_AGC_CHK;
        end
        ST_GATE_M:   state <= ST_GATE_ACC;
        ST_GATE_ACC: state <= ST_GATE_WB;
        ST_GATE_WB:  state <= ST_AGC_CHK;
        ST_AGC_CHK:  state <= status.agc_en ? ST_ENV_M1 : ST_FINISH;
        ST_ENV_M1:   state <= ST_ENV_M2;
        ST_ENV_M2:   state <= ST_ENV_ACC;
        ST_ENV_ACC:  state <= ST_ENV_WB;
        ST_ENV_WB:   state <= ST_GAIN_CHK;
        ST_GAIN_CHK: state <= status.env_big ? ST_DIV_WAIT : ST_GAIN_M;
        ST_DIV_WAIT: begin
          if (!status.div_busy) begin
            state <= ST_GAIN_M;
          end
        end
        ST_GAIN_M:   state <= ST_GAIN_ACC;
        ST_GAIN_ACC: state <= ST_GAIN_WB;
        ST_GAIN_WB:  state <= ST_FINISH;
        ST_FINISH: begin
          // hold until the result register is free
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default:     state <= ST_IDLE;
      endcase
    end
  end

  `AHGA_ASSERT_NEXT(a_leave_idle, clk, rst, in_valid && in_ready, state != ST_IDLE,
                    "accepted sample did not start processing")
  `AHGA_ASSERT_IMP(a_div_start, clk, rst, cmd.div_start, status.env_big && !status.div_busy,
                   "divider started on a small envelope or while busy")
  `AHGA_ASSERT_IMP(a_gain_after_div, clk, rst, state == ST_GAIN_M, !status.div_busy,
                   "gain applied before the divider finished")
  `AHGA_ASSERT_NEXT(a_result_shown, clk, rst, cmd.out_load, out_valid && state == ST_IDLE,
                    "loaded result not presented")

endmodule

// ----- rtl/core/audio_hpf_gate_agc_chain_unit.sv -----
// ----------------------------------------------------------------------------
// Audio conditioning chain: high-pass filter, noise gate, gain control
// Usage:
//   s_axis_* carries one signed Q1.15 sample per transfer; m_axis_* returns
//   one result per sample: the processed sample and the 8-bit envelope level.
//   Registers are written through cfg_wr_en/cfg_index/cfg_data while idle.
// Timing:
//   One sample is processed at a time. With all stages on, the gain divider,
//   one quotient bit a cycle, is the longest step. The next sample is taken
//   as soon as the previous one is in the result register, even while that
//   result still waits.
// Reset:
//   rst clears the filter and envelope state and loads the register defaults;
//   no result is pending afterwards.
// Stall:
//   While m_axis_tready stays low the result holds, one more sample may be
//   processed, and then s_axis_tready stays low until the result is taken.
// ----------------------------------------------------------------------------
module audio_hpf_gate_agc_chain_unit #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEFF_WIDTH  = 16,
  localparam int CFG_DATA_W  = (COEFF_WIDTH > SAMPLE_WIDTH - 1) ? COEFF_WIDTH
                                                                : SAMPLE_WIDTH - 1,
  localparam int IN_TDATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((SAMPLE_WIDTH + 8 + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [IN_TDATA_W-1:0]             s_axis_tdata,  // in_sample
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [OUT_TDATA_W-1:0]            m_axis_tdata,  // out_sample, envelope_level
  input  logic                              cfg_wr_en,
  input  logic [ahga_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]             cfg_data
);
  import ahga_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  logic signed [SAMPLE_WIDTH-1:0] in_sample;
  logic signed [SAMPLE_WIDTH-1:0] out_sample;
  logic [7:0]                     envelope_level;

  assign in_sample    = s_axis_tdata[SAMPLE_WIDTH-1:0];
  assign m_axis_tdata = OUT_TDATA_W'({envelope_level, out_sample});

  ahga_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ahga_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEFF_WIDTH  (COEFF_WIDTH),
    .CFG_DATA_W   (CFG_DATA_W)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_sample      (in_sample),
    .cmd            (cmd),
    .status         (status),
    .out_sample     (out_sample),
    .envelope_level (envelope_level)
  );

endmodule
